// ===== hw/rtl/protobuf_record_field_parser_macros.svh =====
// Assertion macros for the protobuf record field parser.
`ifndef PROTOBUF_RECORD_FIELD_PARSER_MACROS_SVH
`define PROTOBUF_RECORD_FIELD_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define PBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pbf assertion failed");

// Checked only at the clock edge at which rst_n is first sampled high after reset.
`define PBF_ASSERT_POST_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) $rose(rst_n) |-> prop) \
    else $error("pbf reset assertion failed");

`else

`define PBF_ASSERT(lbl, prop)
`define PBF_ASSERT_POST_RST(lbl, prop)

`endif

`endif

// ===== hw/rtl/pbf_pkg.sv =====
// Shared types and constants for the protobuf record field parser.
`default_nettype none

package pbf_pkg;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN,
    PH_VAL,
    PH_PAY,
    PH_ERR
  } pbf_phase_t;

  typedef enum logic [1:0] {
    TGT_NONE,
    TGT_VALUE,
    TGT_SIG,
    TGT_KEY
  } pbf_tgt_t;

  typedef enum logic [2:0] {
    FLD_OTHER,
    FLD_VALUE,
    FLD_SIG,
    FLD_SEQ,
    FLD_KEY,
    FLD_VALIDITY
  } pbf_fld_t;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;

  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
  localparam logic [5:0] VARINT_DIGIT_BITS = 6'd7;

  localparam logic [31:0] FN_VALUE    = 32'd1;
  localparam logic [31:0] FN_SIG      = 32'd2;
  localparam logic [31:0] FN_SEQ      = 32'd4;
  localparam logic [31:0] FN_KEY      = 32'd5;
  localparam logic [31:0] FN_VALIDITY = 32'd6;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_SIG   = 2'd1;
  localparam logic [1:0] KIND_KEY   = 2'd2;

  typedef struct packed {
    logic        payload_valid;
    logic [1:0]  field_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        record_done;
    logic        parse_ok;
    logic [63:0] sequence_number;
    logic [63:0] validity_time;
    logic [7:0]  value_length;
    logic [7:0]  signature_length;
    logic [7:0]  key_length;
  } pbf_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pbf_parse_core.sv =====
// Parser state and per-byte next-state logic: varint decode, field dispatch, capture.
`default_nettype none

module pbf_parse_core #(
  parameter int VALUE_CAPACITY     = 256,
  parameter int SIGNATURE_CAPACITY = 256,
  parameter int KEY_CAPACITY       = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [7:0]         in_byte,
  input  wire logic               eob,
  output logic                    res_valid,
  output pbf_pkg::pbf_result_t    res
);

  localparam logic [8:0] VALUE_CAP = 9'(VALUE_CAPACITY);
  localparam logic [8:0] SIG_CAP   = 9'(SIGNATURE_CAPACITY);
  localparam logic [8:0] KEY_CAP   = 9'(KEY_CAPACITY);

  pbf_pkg::pbf_phase_t phase_r, phase_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  pbf_pkg::pbf_fld_t   fld_r, fld_nxt;
  logic [63:0]         left_r, left_nxt;
  pbf_pkg::pbf_tgt_t   tgt_r, tgt_nxt;
  logic [7:0]          idx_r, idx_nxt;
  logic                err_r, err_nxt;
  logic [63:0]         seq_r, seq_nxt;
  logic [63:0]         valt_r, valt_nxt;
  logic [7:0]          vlen_r, vlen_nxt;
  logic [7:0]          slen_r, slen_nxt;
  logic [7:0]          klen_r, klen_nxt;

  logic [5:0]  shamt;
  logic [63:0] digit;
  logic [63:0] acc_f;
  logic [3:0]  cnt_inc;
  logic [63:0] left_dec;
  logic        len_small;
  logic [1:0]  kind;

  function automatic pbf_pkg::pbf_fld_t fld_decode(input logic [31:0] num);
    pbf_pkg::pbf_fld_t f;
    case (num)
      pbf_pkg::FN_VALUE:    f = pbf_pkg::FLD_VALUE;
      pbf_pkg::FN_SIG:      f = pbf_pkg::FLD_SIG;
      pbf_pkg::FN_SEQ:      f = pbf_pkg::FLD_SEQ;
      pbf_pkg::FN_KEY:      f = pbf_pkg::FLD_KEY;
      pbf_pkg::FN_VALIDITY: f = pbf_pkg::FLD_VALIDITY;
      default:              f = pbf_pkg::FLD_OTHER;
    endcase
    return f;
  endfunction

  assign shamt     = 6'({2'b00, cnt_r} * pbf_pkg::VARINT_DIGIT_BITS);
  assign digit     = {57'b0, in_byte[6:0]} << shamt;
  assign acc_f     = acc_r | digit;
  assign cnt_inc   = cnt_r + 4'd1;
  assign left_dec  = left_r - 64'd1;
  assign len_small = (acc_f[63:9] == '0);

  always_comb begin
    case (tgt_r)
      pbf_pkg::TGT_SIG: kind = pbf_pkg::KIND_SIG;
      pbf_pkg::TGT_KEY: kind = pbf_pkg::KIND_KEY;
      default:          kind = pbf_pkg::KIND_VALUE;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    fld_nxt   = fld_r;
    left_nxt  = left_r;
    tgt_nxt   = tgt_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    seq_nxt   = seq_r;
    valt_nxt  = valt_r;
    vlen_nxt  = vlen_r;
    slen_nxt  = slen_r;
    klen_nxt  = klen_r;
    res       = '0;

    case (phase_r)
      pbf_pkg::PH_TAG, pbf_pkg::PH_LEN, pbf_pkg::PH_VAL: begin
        if (in_byte[7]) begin
          acc_nxt = acc_f;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= pbf_pkg::VARINT_MAX_BYTES) begin
            err_nxt   = 1'b1;
            phase_nxt = pbf_pkg::PH_ERR;
          end
        end else begin
          acc_nxt = '0;
          cnt_nxt = '0;
          case (phase_r)
            pbf_pkg::PH_TAG: begin
              fld_nxt = fld_decode(acc_f[34:3]);
              if (acc_f[2:0] == pbf_pkg::WT_LEN) begin
                phase_nxt = pbf_pkg::PH_LEN;
              end else if (acc_f[2:0] == pbf_pkg::WT_VARINT) begin
                phase_nxt = pbf_pkg::PH_VAL;
              end else begin
                phase_nxt = pbf_pkg::PH_ERR;
                err_nxt   = 1'b1;
              end
            end
            pbf_pkg::PH_LEN: begin
              tgt_nxt  = pbf_pkg::TGT_NONE;
              idx_nxt  = '0;
              left_nxt = acc_f;
              case (fld_r)
                pbf_pkg::FLD_VALUE: begin
                  if (len_small && (acc_f[8:0] < VALUE_CAP)) begin
                    tgt_nxt  = pbf_pkg::TGT_VALUE;
                    vlen_nxt = acc_f[7:0];
                  end
                end
                pbf_pkg::FLD_SIG: begin
                  if (len_small && (acc_f[8:0] < SIG_CAP)) begin
                    tgt_nxt  = pbf_pkg::TGT_SIG;
                    slen_nxt = acc_f[7:0];
                  end
                end
                pbf_pkg::FLD_KEY: begin
                  if (len_small && (acc_f[8:0] < KEY_CAP)) begin
                    tgt_nxt  = pbf_pkg::TGT_KEY;
                    klen_nxt = acc_f[7:0];
                  end
                end
                default: ;
              endcase
              if (acc_f == '0) begin
                phase_nxt = pbf_pkg::PH_TAG;
                tgt_nxt   = pbf_pkg::TGT_NONE;
              end else begin
                phase_nxt = pbf_pkg::PH_PAY;
              end
            end
            default: begin
              if (fld_r == pbf_pkg::FLD_SEQ) begin
                seq_nxt = acc_f;
              end else if (fld_r == pbf_pkg::FLD_VALIDITY) begin
                valt_nxt = acc_f;
              end
              phase_nxt = pbf_pkg::PH_TAG;
            end
          endcase
        end
      end
      pbf_pkg::PH_PAY: begin
        if (tgt_r != pbf_pkg::TGT_NONE) begin
          res.payload_valid = 1'b1;
          res.field_kind    = kind;
          res.data_byte     = in_byte;
          res.byte_index    = idx_r;
          idx_nxt           = idx_r + 8'd1;
        end
        left_nxt = left_dec;
        if (left_dec == '0) begin
          tgt_nxt   = pbf_pkg::TGT_NONE;
          phase_nxt = pbf_pkg::PH_TAG;
          acc_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      default: ;
    endcase

    res_valid = res.payload_valid | eob;

    if (eob) begin
      res.record_done      = 1'b1;
      res.parse_ok         = !err_nxt && (phase_nxt == pbf_pkg::PH_TAG) &&
                             (cnt_nxt == '0) && (acc_nxt == '0);
      res.sequence_number  = seq_nxt;
      res.validity_time    = valt_nxt;
      res.value_length     = vlen_nxt;
      res.signature_length = slen_nxt;
      res.key_length       = klen_nxt;
      phase_nxt = pbf_pkg::PH_TAG;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      fld_nxt   = pbf_pkg::FLD_OTHER;
      left_nxt  = '0;
      tgt_nxt   = pbf_pkg::TGT_NONE;
      idx_nxt   = '0;
      err_nxt   = 1'b0;
      seq_nxt   = '0;
      valt_nxt  = '0;
      vlen_nxt  = '0;
      slen_nxt  = '0;
      klen_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pbf_pkg::PH_TAG;
      acc_r   <= '0;
      cnt_r   <= '0;
      fld_r   <= pbf_pkg::FLD_OTHER;
      left_r  <= '0;
      tgt_r   <= pbf_pkg::TGT_NONE;
      idx_r   <= '0;
      err_r   <= 1'b0;
      seq_r   <= '0;
      valt_r  <= '0;
      vlen_r  <= '0;
      slen_r  <= '0;
      klen_r  <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      fld_r   <= fld_nxt;
      left_r  <= left_nxt;
      tgt_r   <= tgt_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
      seq_r   <= seq_nxt;
      valt_r  <= valt_nxt;
      vlen_r  <= vlen_nxt;
      slen_r  <= slen_nxt;
      klen_r  <= klen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbf_out_reg.sv =====
// Result register between the parser core and the output channel.
`default_nettype none

module pbf_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic                  res_valid,
  input  wire pbf_pkg::pbf_result_t  res,
  input  wire logic                  out_ready,
  output logic                       out_free,
  output logic                       out_valid,
  output pbf_pkg::pbf_result_t       out_res
);

  logic                 valid_r, valid_nxt;
  pbf_pkg::pbf_result_t res_r;
  logic                 load;

  assign out_free  = !valid_r || out_ready;
  assign load      = go && res_valid;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/protobuf_record_field_parser.sv =====
// Top level of the streaming protobuf record field parser.
//
// Input channel (in_valid/in_ready): one encoded record byte per transfer,
// with in_end_of_buffer marking the final byte of a record.
// Output channel (out_valid/out_ready): a transfer for every captured payload
// byte of fields 1, 2 and 5, and one for the final byte of each record
// (out_record_done) carrying out_parse_ok and the kept varints and lengths.
// Bytes that cause no result leave nothing on the output channel.
// A byte taken on the input waits in the input register until the output
// side is free; then the parser state and the result register take it
// together, and its result transfer follows from the result register.
// Throughput: one byte per cycle while results are taken; the parser state
// updates once per byte in one pass; the varint accumulator loop sets the rate.
// A stalled receiver holds the result register; one more byte waits in the
// input register, after which in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a record. After each final byte the parser also
// returns to that state on its own.
`default_nettype none

module protobuf_record_field_parser #(
  parameter int VALUE_CAPACITY     = 256,
  parameter int SIGNATURE_CAPACITY = 256,
  parameter int KEY_CAPACITY       = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_payload_valid,
  output logic [1:0]       out_field_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_byte_index,
  output logic             out_record_done,
  output logic             out_parse_ok,
  output logic [63:0]      out_sequence_number,
  output logic [63:0]      out_validity_time,
  output logic [7:0]       out_value_length,
  output logic [7:0]       out_signature_length,
  output logic [7:0]       out_key_length
);

`include "protobuf_record_field_parser_macros.svh"

  logic                 in_vld_r, in_vld_nxt;
  logic [7:0]           in_byte_r;
  logic                 in_eob_r;
  logic                 in_xfer;
  logic                 go;
  logic                 out_free;
  logic                 res_valid;
  pbf_pkg::pbf_result_t res;
  pbf_pkg::pbf_result_t out_res;

  assign go       = in_vld_r && out_free;
  assign in_ready = !in_vld_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_byte;
      in_eob_r  <= in_end_of_buffer;
    end
  end

  pbf_parse_core #(
    .VALUE_CAPACITY     (VALUE_CAPACITY),
    .SIGNATURE_CAPACITY (SIGNATURE_CAPACITY),
    .KEY_CAPACITY       (KEY_CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .in_byte   (in_byte_r),
    .eob       (in_eob_r),
    .res_valid (res_valid),
    .res       (res)
  );

  pbf_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_payload_valid    = out_res.payload_valid;
  assign out_field_kind       = out_res.field_kind;
  assign out_data_byte        = out_res.data_byte;
  assign out_byte_index       = out_res.byte_index;
  assign out_record_done      = out_res.record_done;
  assign out_parse_ok         = out_res.parse_ok;
  assign out_sequence_number  = out_res.sequence_number;
  assign out_validity_time    = out_res.validity_time;
  assign out_value_length     = out_res.value_length;
  assign out_signature_length = out_res.signature_length;
  assign out_key_length       = out_res.key_length;

  `PBF_ASSERT(a_result_has_cause, out_valid |-> (out_payload_valid || out_record_done))
  `PBF_ASSERT(a_no_payload_clean, (out_valid && !out_payload_valid) |-> (out_data_byte == 8'd0 && out_byte_index == 8'd0 && out_field_kind == pbf_pkg::KIND_VALUE))
  `PBF_ASSERT(a_summary_only_done, (out_valid && !out_record_done) |-> (!out_parse_ok && out_sequence_number == 64'd0 && out_validity_time == 64'd0))
  `PBF_ASSERT(a_ready_when_out_empty, !out_valid |-> in_ready)
  `PBF_ASSERT_POST_RST(a_reset_empties, !out_valid && in_ready)

endmodule

`default_nettype wire
